/* rtl/integer_to_ascii_formatter_assert.svh */
// Assertion macros shared by the formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ITOA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/itoa_pkg.sv */
// Shared constants, types and helper functions of the integer formatter.
package itoa_pkg;

    localparam int VALUE_W        = 64;
    localparam int FIELD_W        = 6;
    localparam int CHAR_W         = 8;
    localparam int DIGIT_W        = 4;
    localparam int MODE_W         = 2;
    localparam int PHASE_W        = 3;

    localparam int MAX_WIDTH_DEF  = 40;
    localparam int MAX_PREC_DEF   = 32;
    localparam int VALUE_BITS_DEF = 64;
    localparam int OUT_LIMIT      = 40;

    localparam logic [MODE_W-1:0] MODE_OCT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HEX = 2'd2;

    typedef logic [PHASE_W-1:0] phase_t;

    localparam phase_t PH_LEAD  = 3'd0;
    localparam phase_t PH_SIGN  = 3'd1;
    localparam phase_t PH_PFX0  = 3'd2;
    localparam phase_t PH_PFX1  = 3'd3;
    localparam phase_t PH_ZERO  = 3'd4;
    localparam phase_t PH_DIG   = 3'd5;
    localparam phase_t PH_TRAIL = 3'd6;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;

    typedef struct packed {
        logic   load;
        logic   dabble;
        logic   norm;
        logic   setup;
        logic   emit;
        phase_t phase;
    } cmd_t;

    typedef struct packed {
        logic dec_mode;
        logic dab_done;
        logic norm_done;
        logic run_zero;
        logic run_one;
        logic slot_free;
        logic final_char;
    } sts_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = (upper ? CH_A_UP : CH_A_LO) + CHAR_W'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

/* rtl/itoa_req_if.sv */
// Conversion request channel: valid/ready plus the request fields.
interface itoa_req_if;
    logic                                valid;
    logic                                ready;
    logic [itoa_pkg::VALUE_W-1:0]        value;
    logic                                negative;
    logic [itoa_pkg::MODE_W-1:0]         mode;
    logic                                upper_case;
    logic                                left_justify;
    logic                                zero_pad;
    logic                                plus_sign;
    logic                                space_sign;
    logic                                alt_form;
    logic [itoa_pkg::FIELD_W-1:0]        field_width;
    logic                                has_precision;
    logic [itoa_pkg::FIELD_W-1:0]        precision;

    modport source (
        output valid, value, negative, mode, upper_case, left_justify, zero_pad,
               plus_sign, space_sign, alt_form, field_width, has_precision, precision,
        input  ready
    );

    modport sink (
        input  valid, value, negative, mode, upper_case, left_justify, zero_pad,
               plus_sign, space_sign, alt_form, field_width, has_precision, precision,
        output ready
    );
endinterface

/* rtl/itoa_chr_if.sv */
// Character output channel: valid/ready plus one character and its last mark.
interface itoa_chr_if;
    logic                         valid;
    logic                         ready;
    logic [itoa_pkg::CHAR_W-1:0]  char_out;
    logic                         last;

    modport source (
        output valid, char_out, last,
        input  ready
    );

    modport sink (
        input  valid, char_out, last,
        output ready
    );
endinterface

/* rtl/integer_to_ascii_formatter.sv */
// Top level of the printf-style integer to ASCII formatter.
//
//  Channel  Direction  Handshake      Transaction
//  req      in         valid/ready    one conversion request (value, flags, width, precision)
//  chr      out        valid/ready    one ASCII character with its last mark
//
//  One request at a time; req.ready is high only while the controller is idle.
//  Decimal: shift-add-3 digit extraction over VALUE_BITS bits; octal and hex load directly.
//  Then leading zero digits are dropped, a setup step sizes the output phases, and the
//  characters (at most 40) are emitted phase by phase, skipping any empty phase.
//  A stalled chr holds the output register and pauses the character sequence.
//  rst_n clears the controller and output valid; no request is lost on a stall.
module integer_to_ascii_formatter #(
    parameter int MAX_WIDTH  = itoa_pkg::MAX_WIDTH_DEF,
    parameter int MAX_PREC   = itoa_pkg::MAX_PREC_DEF,
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    itoa_req_if.sink    req,
    itoa_chr_if.source  chr
);

`include "integer_to_ascii_formatter_assert.svh"

    itoa_pkg::cmd_t cmd;
    itoa_pkg::sts_t sts;
    logic           req_ready;

    itoa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    itoa_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_PREC   (MAX_PREC),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .chr   (chr)
    );

    assign req.ready = req_ready;

    `ITOA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready not dropped")
    `ITOA_ASSERT_NOW(a_emit_needs_slot, cmd.emit, sts.slot_free, "held character overwritten")
    `ITOA_ASSERT_NOW(a_no_emit_idle, req.ready, !cmd.emit, "character emitted while idle")

endmodule

/* rtl/itoa_datapath.sv */
// Formatter datapath: digit extraction, digit shift line, run counters, output register.
module itoa_datapath #(
    parameter int MAX_WIDTH  = itoa_pkg::MAX_WIDTH_DEF,
    parameter int MAX_PREC   = itoa_pkg::MAX_PREC_DEF,
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  itoa_pkg::cmd_t   cmd,
    output itoa_pkg::sts_t   sts,
    itoa_req_if.sink         req,
    itoa_chr_if.source       chr
);

    localparam int NDIG     = (VALUE_BITS + 2) / 3;
    localparam int DIG_BITS = itoa_pkg::DIGIT_W * NDIG;
    localparam int CNT_W    = $clog2(NDIG + 1);
    localparam int BIT_W    = $clog2(VALUE_BITS + 1);
    localparam int FW       = itoa_pkg::FIELD_W;
    localparam int SUM_W    = itoa_pkg::FIELD_W + 1;
    localparam int CW       = itoa_pkg::CHAR_W;
    localparam int DW       = itoa_pkg::DIGIT_W;

    logic [VALUE_BITS-1:0] work_reg;
    logic [DIG_BITS-1:0]   dig_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [BIT_W-1:0]      bit_reg;
    logic                  upper_reg;
    logic                  left_reg;
    logic                  zmode_reg;
    logic                  sign_reg;
    logic                  pfx0_reg;
    logic                  pfx1_reg;
    logic [CW-1:0]         sign_char_reg;
    logic [FW-1:0]         width_reg;
    logic [FW-1:0]         prec_reg;
    logic [FW-1:0]         lead_reg;
    logic [FW-1:0]         zpad_reg;
    logic [FW-1:0]         trail_reg;
    logic [FW-1:0]         out_n_reg;
    logic [FW-1:0]         limit_reg;
    logic                  out_valid_reg;
    logic                  out_last_reg;
    logic [CW-1:0]         out_char_reg;

    logic [DIG_BITS-1:0]   oct_dig;
    logic [DIG_BITS-1:0]   hex_dig;
    logic [DIG_BITS-1:0]   load_dig;
    logic [DIG_BITS-1:0]   bcd_adj;
    logic [FW-1:0]         width_sat;
    logic [FW-1:0]         prec_sat;
    logic [FW-1:0]         cnt_ext;
    logic [FW-1:0]         ndig;
    logic [SUM_W-1:0]      body;
    logic [SUM_W-1:0]      total;
    logic [FW-1:0]         pad;
    logic [FW-1:0]         lead;
    logic [FW-1:0]         zpad;
    logic [FW-1:0]         trail;
    logic [FW-1:0]         limit;
    logic [FW-1:0]         run;
    logic [CW-1:0]         emit_char;
    logic [DW-1:0]         top_dig;

    assign hex_dig = DIG_BITS'(req.value[VALUE_BITS-1:0]);

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            oct_dig[i*DW +: DW] = {1'b0, hex_dig[i*3 +: 3]};
        end
    end

    always_comb
    begin
        if (req.mode == itoa_pkg::MODE_OCT)
        begin
            load_dig = oct_dig;
        end
        else if (req.mode == itoa_pkg::MODE_DEC)
        begin
            load_dig = '0;
        end
        else
        begin
            load_dig = hex_dig;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (dig_reg[i*DW +: DW] >= 4'd5)
            begin
                bcd_adj[i*DW +: DW] = dig_reg[i*DW +: DW] + 4'd3;
            end
            else
            begin
                bcd_adj[i*DW +: DW] = dig_reg[i*DW +: DW];
            end
        end
    end

    assign width_sat = (req.field_width > FW'(MAX_WIDTH)) ? FW'(MAX_WIDTH) : req.field_width;
    assign prec_sat  = (req.precision > FW'(MAX_PREC)) ? FW'(MAX_PREC) : req.precision;

    assign cnt_ext = FW'(cnt_reg);
    assign ndig    = (prec_reg > cnt_ext) ? prec_reg : cnt_ext;
    assign body    = SUM_W'(ndig) + SUM_W'(sign_reg) + SUM_W'({pfx0_reg, 1'b0});
    assign pad     = (SUM_W'(width_reg) > body) ? FW'(SUM_W'(width_reg) - body) : '0;
    assign total   = (SUM_W'(width_reg) > body) ? SUM_W'(width_reg) : body;
    assign limit   = (total > SUM_W'(itoa_pkg::OUT_LIMIT)) ? FW'(itoa_pkg::OUT_LIMIT)
                                                           : FW'(total);
    assign lead    = (!left_reg && !zmode_reg) ? pad : '0;
    assign zpad    = (zmode_reg ? pad : FW'(0)) + (ndig - cnt_ext);
    assign trail   = left_reg ? pad : '0;

    assign top_dig = dig_reg[DIG_BITS-1 -: DW];

    always_comb
    begin
        case (cmd.phase)
            itoa_pkg::PH_LEAD:
            begin
                run       = lead_reg;
                emit_char = itoa_pkg::CH_SPACE;
            end
            itoa_pkg::PH_SIGN:
            begin
                run       = FW'(sign_reg);
                emit_char = sign_char_reg;
            end
            itoa_pkg::PH_PFX0:
            begin
                run       = FW'(pfx0_reg);
                emit_char = itoa_pkg::CH_ZERO;
            end
            itoa_pkg::PH_PFX1:
            begin
                run       = FW'(pfx1_reg);
                emit_char = upper_reg ? itoa_pkg::CH_X_UP : itoa_pkg::CH_X_LO;
            end
            itoa_pkg::PH_ZERO:
            begin
                run       = zpad_reg;
                emit_char = itoa_pkg::CH_ZERO;
            end
            itoa_pkg::PH_DIG:
            begin
                run       = cnt_ext;
                emit_char = itoa_pkg::digit_char(top_dig, upper_reg);
            end
            itoa_pkg::PH_TRAIL:
            begin
                run       = trail_reg;
                emit_char = itoa_pkg::CH_SPACE;
            end
            default:
            begin
                run       = '0;
                emit_char = itoa_pkg::CH_SPACE;
            end
        endcase
    end

    assign sts.dec_mode   = (req.mode == itoa_pkg::MODE_DEC);
    assign sts.dab_done   = (bit_reg == BIT_W'(1));
    assign sts.norm_done  = (cnt_reg == CNT_W'(1)) || (top_dig != '0);
    assign sts.run_zero   = (run == '0);
    assign sts.run_one    = (run == FW'(1));
    assign sts.slot_free  = !out_valid_reg || chr.ready;
    assign sts.final_char = (FW'(out_n_reg + 1'b1) == limit_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            work_reg      <= req.value[VALUE_BITS-1:0];
            dig_reg       <= load_dig;
            cnt_reg       <= CNT_W'(NDIG);
            bit_reg       <= BIT_W'(VALUE_BITS);
            upper_reg     <= req.upper_case;
            left_reg      <= req.left_justify;
            zmode_reg     <= req.zero_pad && !req.left_justify && !req.has_precision;
            sign_reg      <= req.negative || req.plus_sign || req.space_sign;
            sign_char_reg <= req.negative  ? itoa_pkg::CH_MINUS :
                             req.plus_sign ? itoa_pkg::CH_PLUS  : itoa_pkg::CH_SPACE;
            pfx0_reg      <= req.alt_form && req.mode[1];
            pfx1_reg      <= req.alt_form && req.mode[1];
            width_reg     <= width_sat;
            prec_reg      <= req.has_precision ? prec_sat : '0;
        end
        else if (cmd.dabble)
        begin
            work_reg <= work_reg << 1;
            dig_reg  <= {bcd_adj[DIG_BITS-2:0], work_reg[VALUE_BITS-1]};
            bit_reg  <= bit_reg - 1'b1;
        end
        else if (cmd.norm)
        begin
            dig_reg <= dig_reg << DW;
            cnt_reg <= cnt_reg - 1'b1;
        end
        else if (cmd.setup)
        begin
            lead_reg  <= lead;
            zpad_reg  <= zpad;
            trail_reg <= trail;
            limit_reg <= limit;
            out_n_reg <= '0;
        end
        else if (cmd.emit)
        begin
            out_n_reg <= out_n_reg + 1'b1;
            case (cmd.phase)
                itoa_pkg::PH_LEAD:  lead_reg  <= lead_reg - 1'b1;
                itoa_pkg::PH_SIGN:  sign_reg  <= 1'b0;
                itoa_pkg::PH_PFX0:  pfx0_reg  <= 1'b0;
                itoa_pkg::PH_PFX1:  pfx1_reg  <= 1'b0;
                itoa_pkg::PH_ZERO:  zpad_reg  <= zpad_reg - 1'b1;
                itoa_pkg::PH_DIG:
                begin
                    dig_reg <= dig_reg << DW;
                    cnt_reg <= cnt_reg - 1'b1;
                end
                itoa_pkg::PH_TRAIL: trail_reg <= trail_reg - 1'b1;
                default:            lead_reg  <= lead_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (chr.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char_reg <= emit_char;
            out_last_reg <= sts.final_char;
        end
    end

    assign chr.valid    = out_valid_reg;
    assign chr.char_out = out_char_reg;
    assign chr.last     = out_last_reg;

endmodule

/* rtl/itoa_ctrl.sv */
// Formatter controller: sequences extraction, normalization and the output phases.
module itoa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    output itoa_pkg::cmd_t  cmd,
    input  itoa_pkg::sts_t  sts
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DABBLE = 4'd1;
    localparam logic [3:0] S_NORM   = 4'd2;
    localparam logic [3:0] S_SETUP  = 4'd3;
    localparam logic [3:0] S_LEAD   = 4'd4;
    localparam logic [3:0] S_SIGN   = 4'd5;
    localparam logic [3:0] S_PFX0   = 4'd6;
    localparam logic [3:0] S_PFX1   = 4'd7;
    localparam logic [3:0] S_ZERO   = 4'd8;
    localparam logic [3:0] S_DIG    = 4'd9;
    localparam logic [3:0] S_TRAIL  = 4'd10;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [3:0]        succ;
    itoa_pkg::phase_t  phase_sel;

    always_comb
    begin
        unique case (state_reg)
            S_LEAD:
            begin
                phase_sel = itoa_pkg::PH_LEAD;
                succ      = S_SIGN;
            end
            S_SIGN:
            begin
                phase_sel = itoa_pkg::PH_SIGN;
                succ      = S_PFX0;
            end
            S_PFX0:
            begin
                phase_sel = itoa_pkg::PH_PFX0;
                succ      = S_PFX1;
            end
            S_PFX1:
            begin
                phase_sel = itoa_pkg::PH_PFX1;
                succ      = S_ZERO;
            end
            S_ZERO:
            begin
                phase_sel = itoa_pkg::PH_ZERO;
                succ      = S_DIG;
            end
            S_DIG:
            begin
                phase_sel = itoa_pkg::PH_DIG;
                succ      = S_TRAIL;
            end
            default:
            begin
                phase_sel = itoa_pkg::PH_TRAIL;
                succ      = S_IDLE;
            end
        endcase
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.phase  = phase_sel;
        state_next = state_reg;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.dec_mode ? S_DABBLE : S_NORM;
                end
            end
            S_DABBLE:
            begin
                cmd.dabble = 1'b1;
                if (sts.dab_done)
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (sts.norm_done)
                begin
                    state_next = S_SETUP;
                end
                else
                begin
                    cmd.norm = 1'b1;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_LEAD;
            end
            S_LEAD, S_SIGN, S_PFX0, S_PFX1, S_ZERO, S_DIG, S_TRAIL:
            begin
                if (sts.run_zero)
                begin
                    state_next = succ;
                end
                else if (sts.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.final_char)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (sts.run_one)
                    begin
                        state_next = succ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* verif/integer_to_ascii_formatter_checker.sv */
// Monitor and scoreboard for the integer formatter: predicts each conversion and compares characters.
module integer_to_ascii_formatter_checker (
    input  logic clk,
    input  logic rst_n,
    itoa_req_if  req,
    itoa_chr_if  chr,
    output int   fail_count,
    output int   pending,
    output int   requests_seen,
    output int   chars_seen
);

    localparam int DIGIT_SLOTS = 32;
    localparam int VALUE_W     = itoa_pkg::VALUE_W;
    localparam int DIGIT_W     = itoa_pkg::DIGIT_W;
    localparam int CHAR_W      = itoa_pkg::CHAR_W;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } out_char_t;

    out_char_t expected_chars[$];
    int        mismatches = 0;
    int        n_req = 0;
    int        n_chr = 0;

    function automatic void log_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch: %s", what);
        end
    endfunction

    function automatic void predict_conversion();
        logic [VALUE_W-1:0] rest;
        logic [DIGIT_W-1:0] digits[$];
        logic [CHAR_W-1:0]  text[$];
        logic [CHAR_W-1:0]  sign_char;
        string              glyphs;
        int                 width;
        int                 prec;
        int                 ndig;
        int                 pad;
        logic               hex;
        logic               prefix;
        logic               zero_fill;
        logic               has_sign;
        rest = req.value;
        if (itoa_pkg::VALUE_BITS_DEF < VALUE_W)
        begin
            rest &= (VALUE_W'(1) << itoa_pkg::VALUE_BITS_DEF) - VALUE_W'(1);
        end
        hex = req.mode[1];
        width = (req.field_width > itoa_pkg::MAX_WIDTH_DEF) ? itoa_pkg::MAX_WIDTH_DEF
                                                            : int'(req.field_width);
        prec = (req.precision > itoa_pkg::MAX_PREC_DEF) ? itoa_pkg::MAX_PREC_DEF
                                                        : int'(req.precision);
        if (!req.has_precision)
        begin
            prec = 0;
        end
        do
        begin
            if (hex)
            begin
                digits.push_back(rest[3:0]);
                rest = rest >> 4;
            end
            else if (req.mode == itoa_pkg::MODE_OCT)
            begin
                digits.push_back(DIGIT_W'(rest[2:0]));
                rest = rest >> 3;
            end
            else
            begin
                digits.push_back(DIGIT_W'(rest % 10));
                rest = rest / 10;
            end
        end
        while (rest != 0 && digits.size() < DIGIT_SLOTS);

        ndig = (prec > digits.size()) ? prec : digits.size();
        has_sign = req.negative || req.plus_sign || req.space_sign;
        sign_char = req.negative ? itoa_pkg::CH_MINUS
                                 : (req.plus_sign ? itoa_pkg::CH_PLUS : itoa_pkg::CH_SPACE);
        prefix = req.alt_form && hex;
        pad = width - ndig - (has_sign ? 1 : 0) - (prefix ? 2 : 0);
        if (pad < 0)
        begin
            pad = 0;
        end
        zero_fill = req.zero_pad && !req.left_justify && !req.has_precision;
        glyphs = req.upper_case ? "0123456789ABCDEF" : "0123456789abcdef";

        if (!req.left_justify && !zero_fill)
        begin
            repeat (pad) text.push_back(itoa_pkg::CH_SPACE);
        end
        if (has_sign)
        begin
            text.push_back(sign_char);
        end
        if (prefix)
        begin
            text.push_back(itoa_pkg::CH_ZERO);
            text.push_back(req.upper_case ? itoa_pkg::CH_X_UP : itoa_pkg::CH_X_LO);
        end
        if (zero_fill)
        begin
            repeat (pad) text.push_back(itoa_pkg::CH_ZERO);
        end
        repeat (ndig - digits.size()) text.push_back(itoa_pkg::CH_ZERO);
        for (int i = digits.size() - 1; i >= 0; i--)
        begin
            text.push_back(glyphs[digits[i]]);
        end
        if (req.left_justify)
        begin
            repeat (pad) text.push_back(itoa_pkg::CH_SPACE);
        end

        while (text.size() > itoa_pkg::OUT_LIMIT)
        begin
            void'(text.pop_back());
        end
        foreach (text[i])
        begin
            expected_chars.push_back(out_char_t'{text[i], i == text.size() - 1});
        end
    endfunction

    always @(posedge clk)
    begin
        out_char_t got;
        out_char_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                predict_conversion();
                n_req++;
            end
            if (chr.valid && chr.ready)
            begin
                got = out_char_t'{chr.char_out, chr.last};
                n_chr++;
                if (expected_chars.size() == 0)
                begin
                    log_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                           got.code, got.last));
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (got.code !== want.code || got.last !== want.last)
                    begin
                        log_mismatch($sformatf(
                            "character %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                            n_chr, want.code, want.last, got.code, got.last));
                    end
                end
            end
        end
        fail_count    <= mismatches;
        pending       <= expected_chars.size();
        requests_seen <= n_req;
        chars_seen    <= n_chr;
    end

endmodule

/* verif/integer_to_ascii_formatter_tb.sv */
// Testbench top for the integer formatter: clock, reset, request and character traffic, verdict.
module integer_to_ascii_formatter_tb;

    localparam int VALUE_W = itoa_pkg::VALUE_W;
    localparam int MODE_W  = itoa_pkg::MODE_W;
    localparam int FIELD_W = itoa_pkg::FIELD_W;

    localparam logic [MODE_W-1:0] MODE_HEX_ALIAS = 2'd3;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_IDLING  = 180;
    localparam int RANDOM_STEADY  = 80;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               negative;
        logic [MODE_W-1:0]  mode;
        logic               upper_case;
        logic               left_justify;
        logic               zero_pad;
        logic               plus_sign;
        logic               space_sign;
        logic               alt_form;
        logic [FIELD_W-1:0] field_width;
        logic               has_precision;
        logic [FIELD_W-1:0] precision;
    } conv_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   steady_flow = 1'b0;
    bit   long_hold_req = 1'b0;
    int   idle_cycles = 0;
    int   fail_count;
    int   pending;
    int   requests_seen;
    int   chars_seen;

    itoa_req_if req_bus ();
    itoa_chr_if chr_bus ();

    integer_to_ascii_formatter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .chr   (chr_bus)
    );

    integer_to_ascii_formatter_checker conv_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_bus),
        .chr           (chr_bus),
        .fail_count    (fail_count),
        .pending       (pending),
        .requests_seen (requests_seen),
        .chars_seen    (chars_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        return steady_flow ? 0 : int'($urandom_range(0, 10));
    endfunction

    function automatic conv_req_t base_request(input logic [VALUE_W-1:0] value,
                                               input logic [MODE_W-1:0] mode);
        conv_req_t r;
        r = '0;
        r.value = value;
        r.mode = mode;
        return r;
    endfunction

    function automatic conv_req_t random_request();
        conv_req_t r;
        int        pick;
        pick = int'($urandom_range(0, 9));
        r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
        if (pick == 0)
        begin
            r.value = '0;
        end
        else if (pick == 1)
        begin
            r.value = '1;
        end
        r.negative = 1'($urandom_range(0, 1));
        r.mode = MODE_W'($urandom_range(0, 3));
        r.upper_case = 1'($urandom_range(0, 1));
        r.left_justify = 1'($urandom_range(0, 1));
        r.zero_pad = 1'($urandom_range(0, 1));
        r.plus_sign = 1'($urandom_range(0, 1));
        r.space_sign = 1'($urandom_range(0, 1));
        r.alt_form = 1'($urandom_range(0, 1));
        r.has_precision = 1'($urandom_range(0, 1));
        r.field_width = FIELD_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 63)
                                                              : $urandom_range(0, 24));
        r.precision = FIELD_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 63)
                                                            : $urandom_range(0, 12));
        return r;
    endfunction

    task automatic offer_request(input conv_req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.value         <= r.value;
        req_bus.negative      <= r.negative;
        req_bus.mode          <= r.mode;
        req_bus.upper_case    <= r.upper_case;
        req_bus.left_justify  <= r.left_justify;
        req_bus.zero_pad      <= r.zero_pad;
        req_bus.plus_sign     <= r.plus_sign;
        req_bus.space_sign    <= r.space_sign;
        req_bus.alt_form      <= r.alt_form;
        req_bus.field_width   <= r.field_width;
        req_bus.has_precision <= r.has_precision;
        req_bus.precision     <= r.precision;
        do
            @(posedge clk);
        while (!req_bus.ready);
    endtask

    initial
    begin : receiver
        int stall;
        chr_bus.ready <= 1'b0;
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                chr_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = pick_gap();
            if (stall > 0)
            begin
                chr_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            chr_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!chr_bus.valid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (chr_bus.valid && chr_bus.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("integer_to_ascii_formatter_tb NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        conv_req_t r;
        req_bus.valid         <= 1'b0;
        req_bus.value         <= '0;
        req_bus.negative      <= 1'b0;
        req_bus.mode          <= itoa_pkg::MODE_OCT;
        req_bus.upper_case    <= 1'b0;
        req_bus.left_justify  <= 1'b0;
        req_bus.zero_pad      <= 1'b0;
        req_bus.plus_sign     <= 1'b0;
        req_bus.space_sign    <= 1'b0;
        req_bus.alt_form      <= 1'b0;
        req_bus.field_width   <= '0;
        req_bus.has_precision <= 1'b0;
        req_bus.precision     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        r = base_request('0, itoa_pkg::MODE_DEC);
        r.has_precision = 1'b1;
        offer_request(r);
        r = base_request('0, itoa_pkg::MODE_HEX);
        r.alt_form = 1'b1;
        offer_request(r);
        offer_request(base_request('1, itoa_pkg::MODE_OCT));
        offer_request(base_request('1, itoa_pkg::MODE_DEC));
        r = base_request('1, itoa_pkg::MODE_HEX);
        r.upper_case = 1'b1;
        r.alt_form = 1'b1;
        offer_request(r);
        offer_request(base_request('1, MODE_HEX_ALIAS));
        r = base_request(64'd12345, itoa_pkg::MODE_DEC);
        r.negative = 1'b1;
        r.plus_sign = 1'b1;
        r.space_sign = 1'b1;
        offer_request(r);
        r = base_request(64'd42, itoa_pkg::MODE_DEC);
        r.plus_sign = 1'b1;
        r.space_sign = 1'b1;
        offer_request(r);
        r = base_request(64'd42, itoa_pkg::MODE_DEC);
        r.space_sign = 1'b1;
        offer_request(r);
        r = base_request(64'd8, itoa_pkg::MODE_OCT);
        r.alt_form = 1'b1;
        offer_request(r);
        r = base_request(64'd7, itoa_pkg::MODE_DEC);
        r.alt_form = 1'b1;
        offer_request(r);
        r = base_request(64'd99, itoa_pkg::MODE_DEC);
        r.negative = 1'b1;
        r.zero_pad = 1'b1;
        r.field_width = 6'd8;
        offer_request(r);
        r = base_request(64'hab, itoa_pkg::MODE_HEX);
        r.zero_pad = 1'b1;
        r.alt_form = 1'b1;
        r.field_width = 6'd10;
        offer_request(r);
        r = base_request(64'd5, itoa_pkg::MODE_DEC);
        r.zero_pad = 1'b1;
        r.left_justify = 1'b1;
        r.field_width = 6'd6;
        offer_request(r);
        r = base_request(64'd5, itoa_pkg::MODE_DEC);
        r.zero_pad = 1'b1;
        r.has_precision = 1'b1;
        r.precision = 6'd3;
        r.field_width = 6'd8;
        offer_request(r);
        r = base_request(64'd1, itoa_pkg::MODE_DEC);
        r.field_width = '1;
        offer_request(r);
        r = base_request(64'd1, itoa_pkg::MODE_HEX);
        r.has_precision = 1'b1;
        r.precision = '1;
        offer_request(r);
        r = base_request('1, itoa_pkg::MODE_HEX);
        r.negative = 1'b1;
        r.alt_form = 1'b1;
        r.upper_case = 1'b1;
        r.left_justify = 1'b1;
        r.field_width = 6'd40;
        r.has_precision = 1'b1;
        r.precision = 6'd32;
        offer_request(r);
        r = base_request(64'd1, itoa_pkg::MODE_OCT);
        r.field_width = 6'd1;
        offer_request(r);
        r = base_request(64'd123, itoa_pkg::MODE_DEC);
        r.precision = '1;
        offer_request(r);
        r = base_request(64'h8000_0000_0000_0000, itoa_pkg::MODE_DEC);
        r.negative = 1'b1;
        r.plus_sign = 1'b1;
        r.zero_pad = 1'b1;
        r.field_width = 6'd40;
        offer_request(r);
        r = base_request('0, itoa_pkg::MODE_DEC);
        r.plus_sign = 1'b1;
        r.zero_pad = 1'b1;
        r.field_width = 6'd5;
        offer_request(r);

        for (int k = 0; k < RANDOM_IDLING; k++)
        begin
            if (k == 60)
            begin
                long_hold_req = 1'b1;
            end
            offer_request(random_request());
        end
        steady_flow = 1'b1;
        for (int k = 0; k < RANDOM_STEADY; k++)
        begin
            offer_request(random_request());
        end
        req_bus.valid <= 1'b0;
        steady_flow = 1'b0;

        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d conversions and %0d characters across all bases, flags and",
                 requests_seen, chars_seen);
        $display("width/precision corners, with random gaps and one %0d-cycle output hold",
                 LONG_HOLD);
        if (pending != 0)
        begin
            $display("%0d expected characters never arrived", pending);
        end
        if (fail_count == 0 && pending == 0)
        begin
            $display("integer_to_ascii_formatter_tb OK");
        end
        else
        begin
            $display("integer_to_ascii_formatter_tb NOT OK");
        end
        $finish;
    end

endmodule
